FILE: hdl/encoder_rate_estimator_assert.svh
// Assertion macros shared by the encoder rate estimator modules.
// No dependencies; included by the files that carry assertions.
`ifndef ENCODER_RATE_ESTIMATOR_ASSERT_SVH
`define ENCODER_RATE_ESTIMATOR_ASSERT_SVH

// Antecedent true in a cycle implies the consequent in the same cycle.
`define ERE_ASSERT_IMPLIES(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent true in a cycle implies the consequent in the next cycle.
`define ERE_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

// The condition never holds.
`define ERE_ASSERT_NEVER(label, ck, rn, cond, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error(msg);

`endif

FILE: hdl/ere_pkg.sv
// Package of the encoder rate estimator: widths, codes, state type and the
// multiplier request struct. No dependencies.
package ere_pkg;

    localparam int FIELD_W     = 48;   // position and rate fields
    localparam int TIME_W      = 32;
    localparam int CNT_FIELD_W = 16;
    localparam int WRAP_W      = 32;
    localparam int PERIOD_W    = 17;
    localparam int ALPHA_W     = 17;
    localparam int PPR_FRAC    = 28;

    localparam int MCAND_W = 48;
    localparam int MPLR_W  = 32;
    localparam int PROD_W  = MCAND_W + MPLR_W;
    localparam int STEP_W  = $clog2(MPLR_W + 1);

    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 144;
    localparam int OUT_TUSER_W = 1;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [1:0] OP_WRAP   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_RELOAD    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RAD_PULSE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SMOOTHING = 2'd2;

    localparam logic [FIELD_W-1:0] FIELD_MAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [FIELD_W-1:0] FIELD_NEG_MAG = 48'h8000_0000_0000;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 17'h1_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS_GO,
        ST_POS_RUN,
        ST_POS_FIX,
        ST_RATE_GO,
        ST_RATE_RUN,
        ST_DIV_GO,
        ST_DIV_RUN,
        ST_AVG_GO,
        ST_AVG_RUN,
        ST_FINISH
    } ere_state_t;

    typedef struct packed {
        logic               start;
        logic [MCAND_W-1:0] mcand;
        logic [MPLR_W-1:0]  mplr;   // left aligned, consumed from the top bit
        logic [STEP_W-1:0]  steps;
    } mul_req_t;

endpackage

FILE: hdl/ere_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on ere_pkg and the assertion macro header.
`include "encoder_rate_estimator_assert.svh"

module ere_mul
    import ere_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mul_req_t          req,
    output logic              done,
    output logic [PROD_W-1:0] prod
);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  cnt_reg;
    logic [MPLR_W-1:0]  mplr_reg;
    logic [MCAND_W-1:0] mcand_reg;
    logic [PROD_W-1:0]  acc_reg;
    logic [PROD_W-1:0]  acc_next;

    // Accumulator doubles and adds the multiplicand when the top bit is set.
    assign acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                    + (mplr_reg[MPLR_W-1] ? PROD_W'(mcand_reg) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == STEP_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mcand_reg <= req.mcand;
            mplr_reg  <= req.mplr;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            mplr_reg <= {mplr_reg[MPLR_W-2:0], 1'b0};
            acc_reg  <= acc_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

    `ERE_ASSERT_NEVER(a_mul_start_busy, clk, rst_n, req.start && busy_reg, "multiplier restarted while busy")

endmodule

FILE: hdl/ere_div.sv
// Restoring divider, one quotient bit per cycle, with the quotient clamped
// to a given limit. Depends on ere_pkg and the assertion macro header.
`include "encoder_rate_estimator_assert.svh"

module ere_div
    import ere_pkg::*;
#(
    parameter int DVD_W = 84,
    parameter int DEN_W = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DVD_W-1:0]   dividend,
    input  logic [DEN_W-1:0]   divisor,
    input  logic [FIELD_W-1:0] limit,
    output logic               done,
    output logic [FIELD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [FIELD_W-1:0] q_reg;
    logic               ovf_reg;
    logic [FIELD_W-1:0] lim_reg;

    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     diff;
    logic               fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            den_reg <= divisor;
            lim_reg <= limit;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_reg   <= {q_reg[FIELD_W-2:0], fits};
            // Any quotient bit pushed out of the top means the result is huge.
            ovf_reg <= ovf_reg | q_reg[FIELD_W-1];
        end
    end

    assign done     = done_reg;
    assign quotient = (ovf_reg || (q_reg > lim_reg)) ? lim_reg : q_reg;

    `ERE_ASSERT_NEVER(a_div_start_busy, clk, rst_n, start && busy_reg, "divider restarted while busy")

endmodule

FILE: hdl/encoder_rate_estimator.sv
// Top level of the encoder rate estimator; depends on ere_pkg, ere_mul,
// ere_div and the assertion macro header. The block extends a hardware
// pulse counter and estimates angular rate. Each input item carries an op
// in s_axis_tuser: a wrap event moves a signed wrap count up or down by one,
// a start event clears position, wrap count and average and stores the
// time, and a sample event produces one result item holding the absolute
// pulse position (wraps times reload plus one, plus the counter value,
// saturated to 48 bits), the raw rate in radians per microsecond with
// RATE_FRACTION_BITS fraction bits (position change times radians per pulse
// over elapsed microseconds, truncated toward zero and saturated), the
// exponentially smoothed rate, and a flag set when no time has elapsed (raw
// rate then reads zero). Wrap and start ops act at acceptance and unused
// ops are dropped, with the block staying idle. A sample runs through one
// shared bit-serial multiplier three times (position, rate and average)
// and a bit-serial restoring divider; when no time has elapsed the rate
// multiply and the divide are skipped. The divide is the longest step.
// Items are taken one at a time, and a finished result waits in an output
// register, so the next item is accepted while it is pending. Configuration
// writes should only be issued while the block is idle.
`include "encoder_rate_estimator_assert.svh"

module encoder_rate_estimator
    import ere_pkg::*;
#(
    parameter int COUNTER_BITS       = 16,
    parameter int RATE_FRACTION_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // count_down [0], counter_value [16:1], time_us [48:17], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op [1:0]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // position_pulses [47:0], raw_rate [95:48], smoothed_rate [143:96]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // zero_interval [0]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    // Scaling between the 28 fraction bits of the angle per pulse register
    // and the fraction bits of the rate: shift the dividend up or the
    // divisor up.
    localparam int UP      = RATE_FRACTION_BITS - PPR_FRAC;
    localparam int UP_POS  = (UP > 0) ? UP : 0;
    localparam int UP_NEG  = (UP < 0) ? -UP : 0;
    localparam int DVD_W   = PROD_W + UP_POS;
    localparam int DEN_W   = TIME_W + UP_NEG;
    localparam int CNT_EFF = (COUNTER_BITS < CNT_FIELD_W) ? COUNTER_BITS : CNT_FIELD_W;
    localparam logic [CNT_FIELD_W-1:0] CNT_MASK =
        CNT_FIELD_W'((33'd1 << CNT_EFF) - 33'd1);

    // Input item fields.
    logic [1:0]             in_op;
    logic                   in_count_down;
    logic [CNT_FIELD_W-1:0] in_counter_value;
    logic [TIME_W-1:0]      in_time_us;
    logic                   in_accept;

    assign in_op            = s_axis_tuser;
    assign in_count_down    = s_axis_tdata[0];
    assign in_counter_value = s_axis_tdata[16:1];
    assign in_time_us       = s_axis_tdata[48:17];
    assign in_accept        = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    logic [CNT_FIELD_W-1:0] reload_reg;
    logic [MPLR_W-1:0]      rad_pulse_reg;
    logic [ALPHA_W-1:0]     smoothing_reg;

    // Estimator state.
    logic [WRAP_W-1:0]  wrap_count_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic [FIELD_W-1:0] last_pos_reg;
    logic [FIELD_W-1:0] avg_reg;

    // Per-sample working registers.
    ere_state_t             state_reg;
    ere_state_t             state_next;
    logic [CNT_FIELD_W-1:0] sample_cnt_reg;
    logic [TIME_W-1:0]      sample_time_reg;
    logic [FIELD_W-1:0]     pos_reg;
    logic [TIME_W-1:0]      dt_reg;
    logic                   zero_reg;
    logic                   neg_reg;
    logic                   avg_neg_reg;
    logic [FIELD_W-1:0]     raw_reg;

    // Output register.
    logic                   out_valid_reg;
    logic [FIELD_W-1:0]     out_pos_reg;
    logic [FIELD_W-1:0]     out_raw_reg;
    logic [FIELD_W-1:0]     out_avg_reg;
    logic                   out_zero_reg;
    logic                   out_load;

    // Datapath nets.
    mul_req_t               mul_req;
    logic                   mul_done;
    logic [PROD_W-1:0]      mul_prod;
    logic                   div_start;
    logic                   div_done;
    logic [FIELD_W-1:0]     div_quot;
    logic [DVD_W-1:0]       div_dividend;
    logic [DEN_W-1:0]       div_divisor;
    logic [FIELD_W-1:0]     div_limit;

    logic                   w_neg;
    logic [WRAP_W-1:0]      w_mag;
    logic [PERIOD_W-1:0]    period;
    logic [CNT_FIELD_W-1:0] cnt_masked;
    logic [FIELD_W:0]       pos_m;
    logic [FIELD_W:0]       pos_sum;
    logic [FIELD_W:0]       pos_neg_mag;
    logic [FIELD_W-1:0]     pos_calc;
    logic [TIME_W-1:0]      dt_calc;
    logic [FIELD_W:0]       delta;
    logic [FIELD_W-1:0]     delta_mag;
    logic [FIELD_W:0]       avg_diff;
    logic [FIELD_W-1:0]     avg_diff_mag;
    logic [ALPHA_W-1:0]     alpha;
    logic [FIELD_W-1:0]     avg_step;
    logic [FIELD_W-1:0]     new_avg;

    // ------------------------------------------------------------------
    // Configuration port. Writes to an index past the list are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg    <= 16'hFFFF;
            rad_pulse_reg <= '0;
            smoothing_reg <= ALPHA_ONE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_RELOAD:    reload_reg    <= cfg_wdata[CNT_FIELD_W-1:0];
                REG_RAD_PULSE: rad_pulse_reg <= cfg_wdata[MPLR_W-1:0];
                REG_SMOOTHING: smoothing_reg <= cfg_wdata[ALPHA_W-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Position: |wrap count| times period comes from the multiplier; the
    // counter value is then added or subtracted and the sum saturated.
    // ------------------------------------------------------------------
    assign w_neg      = wrap_count_reg[WRAP_W-1];
    assign w_mag      = w_neg ? (~wrap_count_reg + WRAP_W'(1)) : wrap_count_reg;
    assign cnt_masked = sample_cnt_reg & CNT_MASK;
    assign period     = {1'b0, reload_reg & CNT_MASK} + PERIOD_W'(1);
    assign pos_m      = mul_prod[FIELD_W:0];
    assign pos_sum    = pos_m + (FIELD_W+1)'(cnt_masked);
    assign pos_neg_mag = pos_m - (FIELD_W+1)'(cnt_masked);

    always_comb
    begin
        if (!w_neg)
        begin
            pos_calc = (pos_sum > (FIELD_W+1)'(FIELD_MAX)) ? FIELD_MAX : pos_sum[FIELD_W-1:0];
        end
        else if (pos_m <= (FIELD_W+1)'(cnt_masked))
        begin
            // No more negative pulses than the counter holds: small non-negative.
            pos_calc = FIELD_W'((FIELD_W+1)'(cnt_masked) - pos_m);
        end
        else if (pos_neg_mag >= (FIELD_W+1)'(FIELD_NEG_MAG))
        begin
            pos_calc = FIELD_NEG_MAG;
        end
        else
        begin
            pos_calc = ~pos_neg_mag[FIELD_W-1:0] + FIELD_W'(1);
        end
    end

    assign dt_calc = sample_time_reg - last_time_reg;

    // Position change and its magnitude feed the rate multiply.
    assign delta     = {pos_reg[FIELD_W-1], pos_reg} - {last_pos_reg[FIELD_W-1], last_pos_reg};
    assign delta_mag = delta[FIELD_W] ? (~delta[FIELD_W-1:0] + FIELD_W'(1))
                                      : delta[FIELD_W-1:0];

    // The divider sees the full product, scaled to the rate format.
    assign div_dividend = DVD_W'(mul_prod) << UP_POS;
    assign div_divisor  = DEN_W'(dt_reg) << UP_NEG;
    assign div_limit    = neg_reg ? FIELD_NEG_MAG : FIELD_MAX;

    // ------------------------------------------------------------------
    // Moving average: avg += trunc(alpha * (raw - avg) / 2^16), with the
    // weight clamped at one and the truncation done on the magnitude.
    // ------------------------------------------------------------------
    assign alpha        = (smoothing_reg > ALPHA_ONE) ? ALPHA_ONE : smoothing_reg;
    assign avg_diff     = {raw_reg[FIELD_W-1], raw_reg} - {avg_reg[FIELD_W-1], avg_reg};
    assign avg_diff_mag = avg_diff[FIELD_W] ? (~avg_diff[FIELD_W-1:0] + FIELD_W'(1))
                                            : avg_diff[FIELD_W-1:0];
    assign avg_step     = mul_prod[ALPHA_W-1 +: FIELD_W];
    assign new_avg      = avg_neg_reg ? (avg_reg - avg_step) : (avg_reg + avg_step);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (in_op == OP_SAMPLE))
                begin
                    state_next = ST_POS_GO;
                end
            end
            ST_POS_GO:   state_next = ST_POS_RUN;
            ST_POS_RUN:  if (mul_done) state_next = ST_POS_FIX;
            ST_POS_FIX:  state_next = (dt_calc == '0) ? ST_AVG_GO : ST_RATE_GO;
            ST_RATE_GO:  state_next = ST_RATE_RUN;
            ST_RATE_RUN: if (mul_done) state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_RUN;
            ST_DIV_RUN:  if (div_done) state_next = ST_AVG_GO;
            ST_AVG_GO:   state_next = ST_AVG_RUN;
            ST_AVG_RUN:  if (mul_done) state_next = ST_FINISH;
            ST_FINISH:   if (out_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        div_start     = (state_reg == ST_DIV_GO);
        out_load      = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);
        mul_req       = '0;
        unique case (state_reg)
            ST_POS_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.mcand = MCAND_W'(w_mag);
                mul_req.mplr  = {period, {(MPLR_W-PERIOD_W){1'b0}}};
                mul_req.steps = STEP_W'(PERIOD_W);
            end
            ST_RATE_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.mcand = delta_mag;
                mul_req.mplr  = rad_pulse_reg;
                mul_req.steps = STEP_W'(MPLR_W);
            end
            ST_AVG_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.mcand = avg_diff_mag;
                mul_req.mplr  = {alpha, {(MPLR_W-ALPHA_W){1'b0}}};
                mul_req.steps = STEP_W'(ALPHA_W);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Estimator state. Wrap and start events act at acceptance; a sample
    // commits its position, time and average when its result is loaded.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_count_reg <= '0;
            last_time_reg  <= '0;
            last_pos_reg   <= '0;
            avg_reg        <= '0;
        end
        else
        begin
            priority if (in_accept && (in_op == OP_WRAP))
            begin
                wrap_count_reg <= in_count_down ? (wrap_count_reg - WRAP_W'(1))
                                                : (wrap_count_reg + WRAP_W'(1));
            end
            else if (in_accept && (in_op == OP_START))
            begin
                wrap_count_reg <= '0;
                last_pos_reg   <= '0;
                avg_reg        <= '0;
                last_time_reg  <= in_time_us;
            end
            else if (out_load)
            begin
                avg_reg       <= new_avg;
                last_pos_reg  <= pos_reg;
                last_time_reg <= sample_time_reg;
            end
            else
            begin
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (in_op == OP_SAMPLE))
        begin
            sample_cnt_reg  <= in_counter_value;
            sample_time_reg <= in_time_us;
        end
        if (state_reg == ST_POS_FIX)
        begin
            pos_reg  <= pos_calc;
            dt_reg   <= dt_calc;
            zero_reg <= (dt_calc == '0);
            raw_reg  <= '0;
        end
        if (state_reg == ST_RATE_GO)
        begin
            neg_reg <= delta[FIELD_W];
        end
        if ((state_reg == ST_DIV_RUN) && div_done)
        begin
            raw_reg <= neg_reg ? (~div_quot + FIELD_W'(1)) : div_quot;
        end
        if (state_reg == ST_AVG_GO)
        begin
            avg_neg_reg <= avg_diff[FIELD_W];
        end
        if (out_load)
        begin
            out_pos_reg  <= pos_reg;
            out_raw_reg  <= raw_reg;
            out_avg_reg  <= new_avg;
            out_zero_reg <= zero_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_avg_reg, out_raw_reg, out_pos_reg};
    assign m_axis_tuser  = out_zero_reg;

    // ------------------------------------------------------------------
    // Arithmetic units.
    // ------------------------------------------------------------------
    ere_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    ere_div #(
        .DVD_W (DVD_W),
        .DEN_W (DEN_W)
    ) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .limit    (div_limit),
        .done     (div_done),
        .quotient (div_quot)
    );

    `ERE_ASSERT_NEXT(a_sample_starts, clk, rst_n, in_accept && (in_op == OP_SAMPLE), state_reg == ST_POS_GO, "sample did not start the position multiply")
    `ERE_ASSERT_IMPLIES(a_zero_raw, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[95:48] == '0, "zero interval with nonzero raw rate")
    `ERE_ASSERT_IMPLIES(a_unit_alpha, clk, rst_n, (state_reg == ST_FINISH) && (alpha == ALPHA_ONE), new_avg == raw_reg, "unit weight average differs from raw rate")

endmodule

FILE: test/ere_rate_checker.sv
`timescale 1ns / 100ps
// Scoreboard of the encoder rate estimator: watches the input, result and
// register write channels, predicts each result and compares it.
// Depends on ere_pkg for widths, op codes and register indexes.
module ere_rate_checker
    import ere_pkg::*;
#(
    parameter int COUNTER_BITS       = 16,
    parameter int RATE_FRACTION_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    // count_down [0], counter_value [16:1], time_us [48:17], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op [1:0]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // position_pulses [47:0], raw_rate [95:48], smoothed_rate [143:96]
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // zero_interval [0]
    input  logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     mismatches,
    output int                     pending
);

    localparam logic [63:0] CNT_MASK   = (64'd1 << COUNTER_BITS) - 64'd1;
    localparam longint      POS_LIMIT  = longint'(FIELD_MAX);
    localparam longint      NEG_LIMIT  = -longint'(FIELD_NEG_MAG);
    localparam int          TIME_LSB   = CNT_FIELD_W + 1;

    typedef struct packed {
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] raw_rate;
        logic [FIELD_W-1:0] smoothed;
        logic               zero_interval;
    } rate_result_t;

    rate_result_t expected_q[$];

    logic [CNT_FIELD_W-1:0]   reload_reg;
    logic [31:0]              rad_per_pulse;
    logic [ALPHA_W-1:0]       alpha_reg;
    logic signed [WRAP_W-1:0] wraps;
    logic [TIME_W-1:0]        prev_time;
    longint                   prev_position;
    longint                   avg_rate;

    function automatic longint clamp48(longint value);
        if (value > POS_LIMIT)
            return POS_LIMIT;
        if (value < NEG_LIMIT)
            return NEG_LIMIT;
        return value;
    endfunction

    function automatic longint position_of(logic [CNT_FIELD_W-1:0] cnt);
        logic [63:0] span;
        span = (64'(reload_reg) & CNT_MASK) + 64'd1;
        return clamp48(longint'(wraps) * longint'(span) + longint'(64'(cnt) & CNT_MASK));
    endfunction

    // Truncating divide on magnitudes, then saturation to the 48-bit range.
    function automatic longint rate_of(longint delta, logic [TIME_W-1:0] elapsed);
        logic [127:0] numer;
        logic [127:0] denom;
        logic [127:0] quot;
        logic [127:0] ceiling;
        numer = 128'(delta < 0 ? -delta : delta) * 128'(rad_per_pulse);
        denom = 128'(elapsed);
        if (RATE_FRACTION_BITS > PPR_FRAC)
            numer = numer << (RATE_FRACTION_BITS - PPR_FRAC);
        else
            denom = denom << (PPR_FRAC - RATE_FRACTION_BITS);
        quot    = numer / denom;
        ceiling = (delta < 0) ? 128'(FIELD_NEG_MAG) : 128'(FIELD_MAX);
        if (quot > ceiling)
            quot = ceiling;
        return (delta < 0) ? -longint'(quot[63:0]) : longint'(quot[63:0]);
    endfunction

    function automatic longint smooth(longint raw);
        logic [ALPHA_W-1:0] weight;
        longint             diff;
        logic [127:0]       prod;
        longint             shift_by;
        weight   = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
        diff     = raw - avg_rate;
        prod     = 128'(diff < 0 ? -diff : diff) * 128'(weight);
        shift_by = longint'(prod >> 16);
        return (diff < 0) ? avg_rate - shift_by : avg_rate + shift_by;
    endfunction

    function automatic void check_field(string label, logic [FIELD_W-1:0] want_v,
                                        logic [FIELD_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            $error("%s: expected %0d, actual %0d", label, $signed(want_v), $signed(got_v));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rate_result_t      got;
        rate_result_t      want;
        longint            sample_pos;
        longint            sample_rate;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] elapsed;
        if (!rst_n)
        begin
            reload_reg    = 16'hFFFF;
            rad_per_pulse = '0;
            alpha_reg     = ALPHA_ONE;
            wraps         = '0;
            prev_time     = '0;
            prev_position = 0;
            avg_rate      = 0;
            mismatches    = 0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_RELOAD:    reload_reg    = cfg_wdata[CNT_FIELD_W-1:0];
                    REG_RAD_PULSE: rad_per_pulse = cfg_wdata;
                    REG_SMOOTHING: alpha_reg     = cfg_wdata[ALPHA_W-1:0];
                    default:       ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got.position      = m_axis_tdata[FIELD_W-1:0];
                got.raw_rate      = m_axis_tdata[2*FIELD_W-1:FIELD_W];
                got.smoothed      = m_axis_tdata[3*FIELD_W-1:2*FIELD_W];
                got.zero_interval = m_axis_tuser[0];
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    $error("result item with no sample outstanding");
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("position_pulses", want.position, got.position);
                    check_field("raw_rate", want.raw_rate, got.raw_rate);
                    check_field("smoothed_rate", want.smoothed, got.smoothed);
                    check_field("zero_interval", FIELD_W'(want.zero_interval),
                                FIELD_W'(got.zero_interval));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                stamp = s_axis_tdata[CNT_FIELD_W+TIME_W:TIME_LSB];
                case (s_axis_tuser)
                    OP_WRAP:
                        wraps = s_axis_tdata[0] ? wraps - 1 : wraps + 1;
                    OP_START:
                    begin
                        wraps         = '0;
                        prev_position = 0;
                        avg_rate      = 0;
                        prev_time     = stamp;
                    end
                    OP_SAMPLE:
                    begin
                        sample_pos  = position_of(s_axis_tdata[CNT_FIELD_W:1]);
                        elapsed     = stamp - prev_time;
                        sample_rate = (elapsed == '0) ? 0
                                    : rate_of(sample_pos - prev_position, elapsed);
                        avg_rate      = smooth(sample_rate);
                        prev_position = sample_pos;
                        prev_time     = stamp;
                        want.position      = sample_pos[FIELD_W-1:0];
                        want.raw_rate      = sample_rate[FIELD_W-1:0];
                        want.smoothed      = avg_rate[FIELD_W-1:0];
                        want.zero_interval = (elapsed == '0);
                        expected_q.push_back(want);
                    end
                    default:
                        ;
                endcase
            end

            pending <= expected_q.size();
        end
    end

endmodule

FILE: test/tb_encoder_rate_estimator.sv
`timescale 1ns / 100ps
// Top of the encoder rate estimator testbench: clock, reset, item and
// register stimulus, result sink and verdict. Depends on ere_pkg, the block
// itself and ere_rate_checker, which does all prediction and comparison.
module tb_encoder_rate_estimator;
    import ere_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 250;
    localparam int HOLD_CYCLES     = 2000;
    localparam int IDLE_PERCENT    = 14;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 200;

    // The block ignores this code, so it only exercises the decode.
    localparam logic [IN_TUSER_W-1:0] OP_UNUSED = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // count_down [0], counter_value [16:1], time_us [48:17], zero fill above
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // op [1:0]
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // position_pulses [47:0], raw_rate [95:48], smoothed_rate [143:96]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // zero_interval [0]
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int          mismatches;
    int          pending;
    // Raised for a whole phase: neither side idles while it is set.
    logic        steady;
    // Each increment asks the result sink for one long hold-off.
    int          hold_requests;
    // Running microsecond clock used to build well-formed sample sequences.
    logic [31:0] now_us;

    always #CLK_HALF clk = ~clk;

    encoder_rate_estimator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    ere_rate_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // Offers one item, after an optional random gap, and returns at the edge
    // where it is accepted. tvalid stays high into the next call, so a
    // back-to-back item never sees tvalid dropped and raised in one step.
    task automatic send_item(input logic [1:0] op, input logic down,
                             input logic [CNT_FIELD_W-1:0] cnt, input logic [TIME_W-1:0] stamp);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, stamp, cnt, down};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Writes all three registers on consecutive edges with the enable held.
    task automatic apply_settings(input logic [CNT_FIELD_W-1:0] reload,
                                  input logic [31:0] rad_pulse, input logic [ALPHA_W-1:0] alpha);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_RELOAD;
        cfg_wdata <= CFG_DATA_W'(reload);
        @(posedge clk);
        cfg_addr  <= REG_RAD_PULSE;
        cfg_wdata <= rad_pulse;
        @(posedge clk);
        cfg_addr  <= REG_SMOOTHING;
        cfg_wdata <= CFG_DATA_W'(alpha);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Stops offering items, waits for every predicted result, then lets the
    // block finish any trailing wrap or start item before anything else.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result sink: random back-pressure, plus a long hold-off whenever the
    // stimulus asks for one. During the hold the block finishes one sample,
    // parks it in its output register, finishes the next and then has to
    // refuse further input while the sender keeps offering items.
    initial
    begin : result_sink
        int holds_served;
        holds_served  = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial
    begin : stimulus
        int                     phase;
        int                     n;
        int                     pick;
        logic [CNT_FIELD_W-1:0] cnt;
        logic [31:0]            advance_us;
        logic [CNT_FIELD_W-1:0] reload_pick;
        logic [31:0]            rad_pick;
        logic [ALPHA_W-1:0]     alpha_pick;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        steady        = 1'b0;
        hold_requests = 0;
        now_us        = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, full-scale counter and the largest angle per pulse:
        // zero elapsed time, positive and negative rate saturation, time
        // stamps wrapping past all ones, and an ignored op code.
        apply_settings(16'hFFFF, 32'hFFFF_FFFF, ALPHA_ONE);
        send_item(OP_START, 1'b0, 16'h0000, 32'd1000);
        send_item(OP_SAMPLE, 1'b0, 16'h0000, 32'd1000);
        send_item(OP_WRAP, 1'b0, 16'h0000, 32'd0);
        send_item(OP_SAMPLE, 1'b1, 16'hFFFF, 32'd1001);
        send_item(OP_WRAP, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_WRAP, 1'b1, 16'h0000, 32'd0);
        send_item(OP_WRAP, 1'b1, 16'h0000, 32'd0);
        send_item(OP_SAMPLE, 1'b0, 16'h0000, 32'd1002);
        send_item(OP_UNUSED, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_SAMPLE, 1'b0, 16'h5555, 32'd1002);
        send_item(OP_SAMPLE, 1'b1, 16'hAAAA, 32'hFFFF_FFFF);
        send_item(OP_SAMPLE, 1'b0, 16'h0001, 32'd0);
        send_item(OP_START, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_WRAP, 1'b0, 16'h1234, 32'd7);
        send_item(OP_SAMPLE, 1'b0, 16'h0000, 32'd5);
        send_item(OP_UNUSED, 1'b0, 16'h0000, 32'd0);
        settle();

        // A reload of zero makes one wrap span one pulse; no angle per pulse
        // and a zero weight keep both rates at zero.
        apply_settings(16'h0000, 32'h0000_0000, '0);
        send_item(OP_START, 1'b0, 16'h0000, 32'd0);
        send_item(OP_WRAP, 1'b0, 16'h0000, 32'd0);
        send_item(OP_WRAP, 1'b0, 16'h0000, 32'd0);
        send_item(OP_SAMPLE, 1'b0, 16'hFFFF, 32'd10);
        settle();

        // Smoothing weights above one act as exactly one.
        apply_settings(16'h0001, 32'h1000_0000, 17'h1_FFFF);
        send_item(OP_START, 1'b0, 16'h0000, 32'd100);
        send_item(OP_WRAP, 1'b1, 16'h0000, 32'd0);
        send_item(OP_SAMPLE, 1'b0, 16'h0001, 32'd150);
        send_item(OP_SAMPLE, 1'b0, 16'h0000, 32'd151);
        settle();

        // Random part. Each phase gets fresh settings, skewed toward the
        // extremes. Most items form well-formed runs (start, wraps, samples
        // with a rising clock); the rest are unused codes and samples with
        // arbitrary time stamps.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(3))
                0:       reload_pick = 16'hFFFF;
                1:       reload_pick = CNT_FIELD_W'($urandom_range(15));
                default: reload_pick = CNT_FIELD_W'($urandom_range(16'hFFFF));
            endcase
            case ($urandom_range(3))
                0:       rad_pick = 32'hFFFF_FFFF;
                1:       rad_pick = $urandom_range(32'h1000_0000);
                default: rad_pick = $urandom;
            endcase
            case ($urandom_range(4))
                0:       alpha_pick = ALPHA_ONE;
                1:       alpha_pick = '0;
                2:       alpha_pick = ALPHA_W'($urandom_range(17'h1_FFFF, 17'h1_0001));
                default: alpha_pick = ALPHA_W'($urandom_range(17'h0_FFFF, 1));
            endcase
            apply_settings(reload_pick, rad_pick, alpha_pick);

            // One phase runs into a long result hold-off, another runs with
            // no idling on either side.
            if (phase == 1)
                hold_requests <= hold_requests + 1;
            if (phase == 2)
                steady <= 1'b1;

            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(99);
                if ($urandom_range(9) == 0)
                    cnt = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                else
                    cnt = CNT_FIELD_W'($urandom);
                if (pick < 4)
                    send_item(OP_START, 1'($urandom), cnt, now_us);
                else if (pick < 34)
                    send_item(OP_WRAP, 1'($urandom), cnt, $urandom);
                else if (pick < 90)
                begin
                    case ($urandom_range(9))
                        0:       advance_us = '0;
                        1:       advance_us = $urandom;
                        2, 3:    advance_us = $urandom_range(32'h0010_0000, 1);
                        default: advance_us = $urandom_range(1000, 1);
                    endcase
                    now_us = now_us + advance_us;
                    send_item(OP_SAMPLE, 1'($urandom), cnt, now_us);
                end
                else if (pick < 95)
                    send_item(OP_UNUSED, 1'($urandom), cnt, $urandom);
                else
                    send_item(OP_SAMPLE, 1'($urandom), cnt, $urandom);
            end
            steady <= 1'b0;
            settle();
        end

        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop, several times the slowest correct run.
    initial
    begin : watchdog
        #16_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
